@@ rtl/cers_pkg.sv @@
// shared types and constants for the circle and ellipse row span block
`timescale 1ns / 1ps
`default_nettype none
package cers_pkg;

	// shape codes
	localparam logic [1:0] FUNC_DISC    = 2'd0;
	localparam logic [1:0] FUNC_CIRCLE  = 2'd1;
	localparam logic [1:0] FUNC_ELLIPSE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] REG_SURF_W     = 3'd2;
	localparam logic [2:0] REG_SURF_H     = 3'd3;
	localparam logic [2:0] REG_CLIP_LEFT  = 3'd4;
	localparam logic [2:0] REG_CLIP_TOP   = 3'd5;
	localparam logic [2:0] REG_CLIP_RIGHT = 3'd6;
	localparam logic [2:0] REG_CLIP_BOT   = 3'd7;

	// root and quotient widths
	localparam int ROOT_IN_W  = 30;
	localparam int ROOT_OUT_W = 15;
	localparam int QUO_W      = 23;
	localparam int DEN_W      = 15;

	// request word
	typedef struct packed {
		logic        [1:0]  func;
		logic signed [15:0] centre_x;
		logic signed [15:0] centre_y;
		logic signed [15:0] radius_x;
		logic signed [15:0] radius_y;
		logic signed [15:0] row;
		logic        [15:0] colour;
	} req_t;

	// result word
	typedef struct packed {
		logic signed [15:0] span_row;
		logic signed [15:0] span_first;
		logic signed [15:0] span_end;
		logic        [15:0] span_colour;
		logic               last_span;
	} span_t;

	// drawable window, inclusive bounds
	typedef struct packed {
		logic signed [17:0] x0;
		logic signed [17:0] x1;
		logic signed [17:0] y0;
		logic signed [17:0] y1;
	} win_t;

	// per item control carried beside the arithmetic units
	typedef struct packed {
		logic               vld;
		logic               is_disc;
		logic               is_ell;
		logic               live;
		logic               inr;
		logic               inrp;
		logic signed [15:0] cx;
		logic signed [15:0] row;
		logic        [15:0] colour;
	} side_t;

endpackage
`default_nettype wire

@@ rtl/cers_csr.sv @@
// configuration registers and drawable window computation
`timescale 1ns / 1ps
`default_nettype none
module cers_csr #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [2:0]          wr_addr,
	input  wire logic [15:0]         wr_data,
	output cers_pkg::win_t           win
);
	localparam logic signed [33:0] CMIN = -(34'sd1 <<< (COORD_BITS - 1));
	localparam logic signed [33:0] CMAX = (34'sd1 <<< (COORD_BITS - 1)) - 34'sd1;

	logic signed [15:0] origin_x_q, origin_y_q, clip_left_q, clip_top_q;
	logic signed [15:0] clip_right_q, clip_bottom_q;
	logic        [12:0] surf_w_q, surf_h_q;
	logic signed [33:0] x0, x1, y0, y1;
	logic               clip_on;
	cers_pkg::win_t     win_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			surf_w_q      <= 13'd320;
			surf_h_q      <= 13'd240;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= '0;
			clip_bottom_q <= '0;
		end else if (wr_en) begin
			case (wr_addr)
				cers_pkg::REG_ORIGIN_X:   origin_x_q    <= wr_data;
				cers_pkg::REG_ORIGIN_Y:   origin_y_q    <= wr_data;
				cers_pkg::REG_SURF_W:     surf_w_q      <= wr_data[12:0];
				cers_pkg::REG_SURF_H:     surf_h_q      <= wr_data[12:0];
				cers_pkg::REG_CLIP_LEFT:  clip_left_q   <= wr_data;
				cers_pkg::REG_CLIP_TOP:   clip_top_q    <= wr_data;
				cers_pkg::REG_CLIP_RIGHT: clip_right_q  <= wr_data;
				cers_pkg::REG_CLIP_BOT:   clip_bottom_q <= wr_data;
				default: ;
			endcase
		end
	end

	// surface, then clip rectangle, then coordinate range
	always_comb begin
		clip_on = (clip_right_q > clip_left_q) && (clip_bottom_q > clip_top_q);
		x0 = 34'(origin_x_q);
		y0 = 34'(origin_y_q);
		x1 = 34'(origin_x_q) + $signed({21'd0, surf_w_q}) - 34'sd1;
		y1 = 34'(origin_y_q) + $signed({21'd0, surf_h_q}) - 34'sd1;
		if (clip_on) begin
			if (34'(clip_left_q) > x0) x0 = 34'(clip_left_q);
			if (34'(clip_top_q) > y0) y0 = 34'(clip_top_q);
			if (34'(clip_right_q) - 34'sd1 < x1) x1 = 34'(clip_right_q) - 34'sd1;
			if (34'(clip_bottom_q) - 34'sd1 < y1) y1 = 34'(clip_bottom_q) - 34'sd1;
		end
		if (x0 < CMIN) x0 = CMIN;
		if (y0 < CMIN) y0 = CMIN;
		if (x1 > CMAX) x1 = CMAX;
		if (y1 > CMAX) y1 = CMAX;
	end

	// window register, holding the window computed from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else begin
			win_q.x0 <= x0[17:0];
			win_q.x1 <= x1[17:0];
			win_q.y0 <= y0[17:0];
			win_q.y1 <= y1[17:0];
		end
	end

	assign win = win_q;
endmodule
`default_nettype wire

@@ rtl/cers_root.sv @@
// pipelined floor square root, one input bit pair per stage
`timescale 1ns / 1ps
`default_nettype none
module cers_root (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [cers_pkg::ROOT_IN_W-1:0]    val,
	output      logic [cers_pkg::ROOT_OUT_W-1:0]   root
);
	localparam int STEPS = cers_pkg::ROOT_IN_W / 2 + 1;

	logic [31:0] v_q [STEPS];
	logic [31:0] r_q [STEPS];

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			localparam logic [31:0] BIT = 32'd1 << (cers_pkg::ROOT_IN_W - 2 * k);
			logic [31:0] v_in, r_in, cand;

			// previous stage or input
			if (k == 0) begin : g_first
				assign v_in = 32'(val);
				assign r_in = '0;
			end else begin : g_next
				assign v_in = v_q[k-1];
				assign r_in = r_q[k-1];
			end

			assign cand = r_in + BIT;

			// one trial subtract
			always_ff @(posedge clk) begin
				if (en) begin
					if (v_in >= cand) begin
						v_q[k] <= v_in - cand;
						r_q[k] <= (r_in >> 1) + BIT;
					end else begin
						v_q[k] <= v_in;
						r_q[k] <= r_in >> 1;
					end
				end
			end
		end
	endgenerate

	assign root = r_q[STEPS-1][cers_pkg::ROOT_OUT_W-1:0];
endmodule
`default_nettype wire

@@ rtl/cers_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cers_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [cers_pkg::QUO_W-1:0]    dvd,
	input  wire logic [cers_pkg::DEN_W-1:0]    den,
	output      logic [cers_pkg::QUO_W-1:0]    quo
);
	localparam int QW = cers_pkg::QUO_W;
	localparam int DW = cers_pkg::DEN_W;

	logic [DW:0]   rem_q [QW];
	logic [QW-1:0] dvd_q [QW];
	logic [QW-1:0] quo_q [QW];
	logic [DW-1:0] den_q [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_step
			logic [DW:0]   rem_in, trial;
			logic [QW-1:0] dvd_in, quo_in;
			logic [DW-1:0] den_in;

			// previous stage or input
			if (k == 0) begin : g_first
				assign rem_in = '0;
				assign dvd_in = dvd;
				assign quo_in = '0;
				assign den_in = den;
			end else begin : g_next
				assign rem_in = rem_q[k-1];
				assign dvd_in = dvd_q[k-1];
				assign quo_in = quo_q[k-1];
				assign den_in = den_q[k-1];
			end

			assign trial = {rem_in[DW-1:0], dvd_in[QW-1]};

			// one quotient bit
			always_ff @(posedge clk) begin
				if (en) begin
					den_q[k] <= den_in;
					dvd_q[k] <= {dvd_in[QW-2:0], 1'b0};
					if (trial >= {1'b0, den_in}) begin
						rem_q[k] <= trial - {1'b0, den_in};
						quo_q[k] <= {quo_in[QW-2:0], 1'b1};
					end else begin
						rem_q[k] <= trial;
						quo_q[k] <= {quo_in[QW-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign quo = quo_q[QW-1];
endmodule
`default_nettype wire

@@ rtl/cers_delay.sv @@
// shift line that keeps words in step with the arithmetic units
`timescale 1ns / 1ps
`default_nettype none
module cers_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output      logic [W-1:0] dout
);
	logic [W-1:0] line_q [DEPTH];

	// shift on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
		end else if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign dout = line_q[DEPTH-1];
endmodule
`default_nettype wire

@@ rtl/circle_ellipse_row_spans.sv @@
// top level of the circle and ellipse row span rasterizer
`timescale 1ns / 1ps
`default_nettype none
// Takes one row request (shape, centre, radii, row, colour) and gives the
// clipped horizontal spans of that shape on the row, up to four of them,
// the final one marked by last_span.
// Request channel: a word on req is taken at a clock edge where start is high
// and busy is low. Result channel: strobe is high for exactly one cycle per
// span word on span; the receiver cannot hold results off.
// Configuration: wr_en, wr_addr and wr_data write one register per edge; the
// window they define is computed from the registers and registered again before use.
// Pipeline: 27 stages, set by the 23 stage quotient divider for the ellipse
// ratio running beside the 16 stage square roots, followed by the scale
// multiply and the span and clip stages.
// Throughput: one request per cycle when each gives at most one span; a
// request with several spans holds the pipeline, and busy, while the output
// stage sends its spans one per cycle.
// Reset clears all valid bits and restores the register reset values.
module circle_ellipse_row_spans #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output      logic                busy,
	input  wire cers_pkg::req_t      req,
	output      logic                strobe,
	output      cers_pkg::span_t     span,
	input  wire logic                wr_en,
	input  wire logic [2:0]          wr_addr,
	input  wire logic [15:0]         wr_data
);
	localparam int SIDE_W   = $bits(cers_pkg::side_t);
	localparam int SIDE_LAG = 20;
	localparam int ROOT_LAG = 4;

	cers_pkg::win_t     win;
	logic               adv;
	logic               stall;

	logic               vld_s1;
	cers_pkg::req_t     req_s1;

	cers_pkg::side_t    side_c2, side_s2, side_s3, side_s4, side_s24, side_s25, side_s26;
	cers_pkg::side_t    side_c3;
	logic signed [17:0] dy_c2, dy_s2, dyp_s2;
	logic        [14:0] rad_s2;
	logic               ok_c2;

	logic        [17:0] dya_c3, dypa_c3;
	logic        [33:0] dy2_c3, dyp2_c3;
	logic        [29:0] rad2_s3, dy2_s3, dyp2_s3;

	logic        [29:0] v_s4, vp_s4;

	logic        [14:0] root_w, rootp_w;
	logic        [29:0] roots_s24;
	logic        [22:0] scale_s24;

	logic        [37:0] prod_c25, prodp_c25;
	logic        [14:0] hw_s25, prev_s25;

	logic signed [17:0] cx_c26, hw_c26, pv_c26, lo_c26, hi_c26;
	logic signed [17:0] a_c26 [4];
	logic signed [17:0] b_c26 [4];
	logic        [3:0]  want_c26;
	logic               row_ok_c26;
	logic signed [17:0] a_s26 [4];
	logic signed [17:0] b_s26 [4];
	logic        [3:0]  want_s26;

	logic signed [17:0] a_c27 [4];
	logic signed [17:0] b_c27 [4];
	logic        [3:0]  keep_c27;
	logic               vld_s27;
	logic        [3:0]  mask_s27;
	logic signed [15:0] first_s27 [4];
	logic signed [15:0] end_s27 [4];
	logic signed [15:0] row_s27;
	logic        [15:0] colour_s27;
	logic        [3:0]  rest;
	logic        [1:0]  pick;

	// configuration
	cers_csr #(.COORD_BITS(COORD_BITS)) u_csr (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.win     (win)
	);

	// whole pipeline moves unless the output stage still has spans after this one
	assign rest  = mask_s27 & (mask_s27 - 4'd1);
	assign stall = vld_s27 && (rest != 4'd0);
	assign adv   = !stall;
	assign busy  = stall;

	// stage 1: request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) req_s1 <= req;
	end

	// stage 2: offsets, radius choice and shape checks
	always_comb begin
		dy_c2 = 18'(req_s1.row) - 18'(req_s1.centre_y);
		case (req_s1.func)
			cers_pkg::FUNC_DISC:    ok_c2 = !req_s1.radius_x[15];
			cers_pkg::FUNC_CIRCLE:  ok_c2 = (req_s1.radius_x > 16'sd0);
			cers_pkg::FUNC_ELLIPSE: ok_c2 = (req_s1.radius_x > 16'sd0) &&
			                                (req_s1.radius_y > 16'sd0);
			default:                ok_c2 = 1'b0;
		endcase
		side_c2         = '0;
		side_c2.vld     = vld_s1;
		side_c2.is_disc = (req_s1.func == cers_pkg::FUNC_DISC);
		side_c2.is_ell  = (req_s1.func == cers_pkg::FUNC_ELLIPSE);
		side_c2.live    = ok_c2;
		side_c2.cx      = req_s1.centre_x;
		side_c2.row     = req_s1.row;
		side_c2.colour  = req_s1.colour;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2 <= side_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dy_s2  <= dy_c2;
			dyp_s2 <= dy_c2 - 18'sd1;
			rad_s2 <= (req_s1.func == cers_pkg::FUNC_ELLIPSE) ?
			          req_s1.radius_y[14:0] : req_s1.radius_x[14:0];
		end
	end

	// ellipse ratio rx*256/ry, runs beside stages 2 to 24
	cers_div u_div (
		.clk (clk),
		.en  (adv),
		.dvd ({req_s1.radius_x[14:0], 8'd0}),
		.den (req_s1.radius_y[14:0]),
		.quo (scale_s24)
	);

	// stage 3: squares and row range checks
	always_comb begin
		dya_c3  = dy_s2[17] ? 18'(-dy_s2) : 18'(dy_s2);
		dypa_c3 = dyp_s2[17] ? 18'(-dyp_s2) : 18'(dyp_s2);
		dy2_c3  = dya_c3[16:0] * dya_c3[16:0];
		dyp2_c3 = dypa_c3[16:0] * dypa_c3[16:0];
		side_c3      = side_s2;
		side_c3.inr  = (dya_c3 <= {3'd0, rad_s2});
		side_c3.inrp = (dypa_c3 <= {3'd0, rad_s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3 <= side_c3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad2_s3 <= rad_s2 * rad_s2;
			dy2_s3  <= dy2_c3[29:0];
			dyp2_s3 <= dyp2_c3[29:0];
		end
	end

	// stage 4: root operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (adv) begin
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s4  <= rad2_s3 - dy2_s3;
			vp_s4 <= rad2_s3 - dyp2_s3;
		end
	end

	// square roots for this row and the row above
	cers_root u_root (
		.clk  (clk),
		.en   (adv),
		.val  (v_s4),
		.root (root_w)
	);

	cers_root u_rootp (
		.clk  (clk),
		.en   (adv),
		.val  (vp_s4),
		.root (rootp_w)
	);

	// align roots with the quotient
	cers_delay #(.W(30), .DEPTH(ROOT_LAG)) u_root_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    ({root_w, rootp_w}),
		.dout   (roots_s24)
	);

	// control word beside the units
	cers_delay #(.W(SIDE_W), .DEPTH(SIDE_LAG)) u_side_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (side_s4),
		.dout   (side_s24)
	);

	// stage 25: ellipse scaling
	assign prod_c25  = scale_s24 * roots_s24[29:15];
	assign prodp_c25 = scale_s24 * roots_s24[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s25 <= '0;
		end else if (adv) begin
			side_s25 <= side_s24;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hw_s25   <= side_s24.is_ell ? prod_c25[22:8] : roots_s24[29:15];
			prev_s25 <= side_s24.is_ell ? prodp_c25[22:8] : roots_s24[14:0];
		end
	end

	// stage 26: raw spans, bridges first, then both edge pixels; a disc gives one whole span
	always_comb begin
		cx_c26 = 18'(side_s25.cx);
		hw_c26 = $signed({3'd0, hw_s25});
		pv_c26 = $signed({3'd0, prev_s25});
		lo_c26 = (hw_c26 < pv_c26) ? hw_c26 : pv_c26;
		hi_c26 = (hw_c26 < pv_c26) ? pv_c26 : hw_c26;
		row_ok_c26 = (18'(side_s25.row) >= win.y0) && (18'(side_s25.row) <= win.y1);
		a_c26[0] = cx_c26 - hi_c26;
		b_c26[0] = cx_c26 - lo_c26;
		a_c26[1] = cx_c26 + lo_c26;
		b_c26[1] = cx_c26 + hi_c26;
		a_c26[2] = cx_c26 - hw_c26;
		b_c26[2] = cx_c26 - hw_c26;
		a_c26[3] = cx_c26 + hw_c26;
		b_c26[3] = cx_c26 + hw_c26;
		if (side_s25.is_disc) begin
			b_c26[0] = cx_c26 + hw_c26;
			a_c26[0] = cx_c26 - hw_c26;
			want_c26 = 4'b0001;
		end else begin
			want_c26 = {2'b11, {2{side_s25.inrp && (hi_c26 - lo_c26 > 18'sd1)}}};
		end
		if (!(side_s25.vld && side_s25.live && side_s25.inr && row_ok_c26)) begin
			want_c26 = 4'b0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s26 <= '0;
			want_s26 <= '0;
		end else if (adv) begin
			side_s26 <= side_s25;
			want_s26 <= want_c26;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				a_s26[i] <= a_c26[i];
				b_s26[i] <= b_c26[i];
			end
		end
	end

	// stage 27: clip each span on its own, drop empty ones
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_c27[i]    = (a_s26[i] < win.x0) ? win.x0 : a_s26[i];
			b_c27[i]    = (b_s26[i] > win.x1) ? win.x1 : b_s26[i];
			keep_c27[i] = want_s26[i] && (b_c27[i] >= a_c27[i]);
		end
	end

	// output stage: loads on advance, otherwise retires one span per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s27  <= 1'b0;
			mask_s27 <= '0;
		end else if (adv) begin
			vld_s27  <= side_s26.vld;
			mask_s27 <= keep_c27;
		end else begin
			mask_s27 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s27    <= side_s26.row;
			colour_s27 <= side_s26.colour;
			for (int i = 0; i < 4; i++) begin
				first_s27[i] <= a_c27[i][15:0];
				end_s27[i]   <= b_c27[i][15:0];
			end
		end
	end

	// lowest pending span goes out
	always_comb begin
		if (mask_s27[0])      pick = 2'd0;
		else if (mask_s27[1]) pick = 2'd1;
		else if (mask_s27[2]) pick = 2'd2;
		else                  pick = 2'd3;
	end

	assign strobe           = vld_s27 && (mask_s27 != 4'd0);
	assign span.span_row    = row_s27;
	assign span.span_first  = first_s27[pick];
	assign span.span_end    = end_s27[pick];
	assign span.span_colour = colour_s27;
	assign span.last_span   = (rest == 4'd0);

`ifndef SYNTHESIS
	// holding the input only happens while spans are going out
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> strobe)
		else $error("busy without a span on the output");

	// a span that is not the last is followed at once by another
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !span.last_span |=> strobe)
		else $error("spans of one request not back to back");

	// when the input is open the span on the output ends its request
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !busy |-> span.last_span)
		else $error("pipeline advanced with spans still pending");
`endif
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for the circle and ellipse row span rasterizer
`timescale 1ns / 1ps
module testbench;

	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cers_pkg::req_t   req = '0;
	logic             strobe;
	cers_pkg::span_t  span;
	logic             wr_en = 1'b0;
	logic [2:0]       wr_addr = '0;
	logic [15:0]      wr_data = '0;

	circle_ellipse_row_spans dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.strobe(strobe), .span(span), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// register copies used by the span predictor
	longint win_ox = 0, win_oy = 0, surf_w = 320, surf_h = 240;
	longint clip_l = 0, clip_t = 0, clip_r = 0, clip_b = 0;

	cers_pkg::req_t   pending_reqs[$];
	cers_pkg::span_t  expected_spans[$];
	int     idle_pct = 0;
	int     errors = 0;
	int     reqs_taken = 0;
	int     spans_seen = 0;
	int     cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// floor square root, one result bit at a time from the top
	function automatic longint floor_root(longint v);
		longint r = 0;
		longint t;
		for (int b = 15; b >= 0; b--) begin
			t = r + (longint'(1) << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// half-width at vertical offset dy, -1 outside the shape
	function automatic longint row_half_width(longint rad, longint dy, longint scale);
		longint s;
		if (dy < -rad || dy > rad)
			return -1;
		s = floor_root(rad * rad - dy * dy);
		if (scale < 0)
			return s;
		return (scale * s) >> 8;
	endfunction

	// clip one span and append it when anything is left
	function automatic void clip_span(ref cers_pkg::span_t row_spans[$], input longint row,
			input longint a, input longint b, input longint xlo, input longint xhi,
			input logic [15:0] col);
		cers_pkg::span_t s;
		if (a < xlo) a = xlo;
		if (b > xhi) b = xhi;
		if (b < a)
			return;
		s.span_row    = row[15:0];
		s.span_first  = a[15:0];
		s.span_end    = b[15:0];
		s.span_colour = col;
		s.last_span   = 1'b0;
		row_spans.push_back(s);
	endfunction

	// work out the spans of one request and queue them
	function automatic void predict_row_spans(cers_pkg::req_t r);
		cers_pkg::span_t row_spans[$];
		longint cx = r.centre_x, cy = r.centre_y;
		longint rx = r.radius_x, ry = r.radius_y, row = r.row;
		longint x0 = win_ox, y0 = win_oy;
		longint x1 = win_ox + surf_w - 1, y1 = win_oy + surf_h - 1;
		longint rad, scale = -1, hw, prev, lo, hi;
		if (clip_r > clip_l && clip_b > clip_t) begin
			if (clip_l > x0) x0 = clip_l;
			if (clip_t > y0) y0 = clip_t;
			if (clip_r - 1 < x1) x1 = clip_r - 1;
			if (clip_b - 1 < y1) y1 = clip_b - 1;
		end
		if (x0 < -32768) x0 = -32768;
		if (y0 < -32768) y0 = -32768;
		if (x1 > 32767) x1 = 32767;
		if (y1 > 32767) y1 = 32767;
		if (row < y0 || row > y1)
			return;
		case (r.func)
			cers_pkg::FUNC_DISC: begin
				if (rx < 0) return;
				rad = rx;
			end
			cers_pkg::FUNC_CIRCLE: begin
				if (rx < 1) return;
				rad = rx;
			end
			cers_pkg::FUNC_ELLIPSE: begin
				if (rx < 1 || ry < 1) return;
				rad = ry;
				scale = (rx * 256) / ry;
			end
			default: return;
		endcase
		hw = row_half_width(rad, row - cy, scale);
		if (hw < 0)
			return;
		if (r.func == cers_pkg::FUNC_DISC) begin
			clip_span(row_spans, row, cx - hw, cx + hw, x0, x1, r.colour);
		end else begin
			prev = row_half_width(rad, row - 1 - cy, scale);
			if (prev >= 0) begin
				lo = (hw < prev) ? hw : prev;
				hi = (hw < prev) ? prev : hw;
				if (hi - lo > 1) begin
					clip_span(row_spans, row, cx - hi, cx - lo, x0, x1, r.colour);
					clip_span(row_spans, row, cx + lo, cx + hi, x0, x1, r.colour);
				end
			end
			clip_span(row_spans, row, cx - hw, cx - hw, x0, x1, r.colour);
			clip_span(row_spans, row, cx + hw, cx + hw, x0, x1, r.colour);
		end
		if (row_spans.size() > 0)
			row_spans[row_spans.size() - 1].last_span = 1'b1;
		foreach (row_spans[i])
			expected_spans.push_back(row_spans[i]);
	endfunction

	// request driver: one start per word, held until taken
	always @(posedge clk) begin
		if (arst_n && !(start && busy)) begin
			if (start) begin
				predict_row_spans(req);
				reqs_taken <= reqs_taken + 1;
			end
			if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				req   <= pending_reqs.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// span monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			spans_seen <= spans_seen + 1;
			if (expected_spans.size() == 0) begin
				$error("unexpected span word row=%0d first=%0d end=%0d",
					span.span_row, span.span_first, span.span_end);
				errors++;
			end else begin
				cers_pkg::span_t e;
				e = expected_spans.pop_front();
				if (span.span_row !== e.span_row) begin
					$error("span_row expected %0d got %0d", e.span_row, span.span_row);
					errors++;
				end
				if (span.span_first !== e.span_first) begin
					$error("span_first expected %0d got %0d", e.span_first, span.span_first);
					errors++;
				end
				if (span.span_end !== e.span_end) begin
					$error("span_end expected %0d got %0d", e.span_end, span.span_end);
					errors++;
				end
				if (span.span_colour !== e.span_colour) begin
					$error("span_colour expected %h got %h", e.span_colour, span.span_colour);
					errors++;
				end
				if (span.last_span !== e.last_span) begin
					$error("last_span expected %b got %b", e.last_span, span.last_span);
					errors++;
				end
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("circle_ellipse_row_spans test failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		wr_en   <= 1'b1;
		wr_addr <= idx;
		wr_data <= val;
		case (idx)
			cers_pkg::REG_ORIGIN_X:   win_ox = longint'($signed(val));
			cers_pkg::REG_ORIGIN_Y:   win_oy = longint'($signed(val));
			cers_pkg::REG_SURF_W:     surf_w = longint'(val[12:0]);
			cers_pkg::REG_SURF_H:     surf_h = longint'(val[12:0]);
			cers_pkg::REG_CLIP_LEFT:  clip_l = longint'($signed(val));
			cers_pkg::REG_CLIP_TOP:   clip_t = longint'($signed(val));
			cers_pkg::REG_CLIP_RIGHT: clip_r = longint'($signed(val));
			cers_pkg::REG_CLIP_BOT:   clip_b = longint'($signed(val));
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_window(longint ox, longint oy, longint w, longint h,
			longint cl, longint ct, longint cr, longint cb);
		write_reg(cers_pkg::REG_ORIGIN_X, ox[15:0]);
		write_reg(cers_pkg::REG_ORIGIN_Y, oy[15:0]);
		write_reg(cers_pkg::REG_SURF_W, w[15:0]);
		write_reg(cers_pkg::REG_SURF_H, h[15:0]);
		write_reg(cers_pkg::REG_CLIP_LEFT, cl[15:0]);
		write_reg(cers_pkg::REG_CLIP_TOP, ct[15:0]);
		write_reg(cers_pkg::REG_CLIP_RIGHT, cr[15:0]);
		write_reg(cers_pkg::REG_CLIP_BOT, cb[15:0]);
		repeat (3) @(posedge clk);
	endtask

	task automatic queue_req(logic [1:0] f, longint cx, longint cy, longint rx,
			longint ry, longint row, logic [15:0] col);
		cers_pkg::req_t r;
		r.func     = f;
		r.centre_x = cx[15:0];
		r.centre_y = cy[15:0];
		r.radius_x = rx[15:0];
		r.radius_y = ry[15:0];
		r.row      = row[15:0];
		r.colour   = col;
		pending_reqs.push_back(r);
	endtask

	function automatic longint pick(longint lo, longint hi);
		return lo + longint'($urandom_range(32'(hi - lo)));
	endfunction

	function automatic longint pick_radius();
		int k = $urandom_range(99);
		if (k < 75) return pick(0, 40);
		if (k < 85) return pick(0, 32767);
		if (k < 93) return -pick(1, 32768);
		return pick(0, 1);
	endfunction

	// mostly rows that cut through the shape, some pure noise
	task automatic queue_random(int n, longint xlo, longint xhi, longint ylo, longint yhi);
		logic [1:0] f;
		longint rx, ry, cx, row, dy, span_r;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(9);
			f = (k < 3) ? cers_pkg::FUNC_DISC : (k < 6) ? cers_pkg::FUNC_CIRCLE :
				(k < 9) ? cers_pkg::FUNC_ELLIPSE : FUNC_UNUSED;
			if ($urandom_range(9) == 0) begin
				queue_req(2'($urandom), longint'($urandom), longint'($urandom),
					longint'($urandom), longint'($urandom), longint'($urandom),
					16'($urandom));
			end else begin
				rx = pick_radius();
				ry = pick_radius();
				span_r = (f == cers_pkg::FUNC_ELLIPSE) ? ry : rx;
				if (span_r < 0) span_r = -span_r;
				if (span_r > 40000) span_r = 40000;
				cx  = pick(xlo, xhi);
				row = pick(ylo, yhi);
				dy  = pick(-span_r - 2, span_r + 2);
				queue_req(f, cx, row - dy, rx, ry, row, 16'($urandom));
			end
		end
	endtask

	// let the queue drain and the pipeline settle before touching registers
	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_spans.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows under the reset window
		idle_pct = 0;
		queue_req(cers_pkg::FUNC_DISC, 100, 100, 0, 0, 100, 16'hFFFF);
		queue_req(cers_pkg::FUNC_DISC, 100, 100, 0, 0, 101, 16'h0000);
		queue_req(cers_pkg::FUNC_DISC, 100, 100, -1, 5, 100, 16'h1234);
		queue_req(FUNC_UNUSED, 100, 100, 10, 10, 100, 16'h5555);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 100, 1, 0, 99, 16'hAAAA);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 100, 1, 0, 100, 16'h0F0F);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 100, 1, 0, 101, 16'hF0F0);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 100, 0, 0, 100, 16'h00FF);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 100, 10, 0, 90, 16'h8001);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 100, 10, 0, 91, 16'h7FFE);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 100, 10, 0, 110, 16'h3C3C);
		queue_req(cers_pkg::FUNC_CIRCLE, 2, 50, 20, 0, 45, 16'hC3C3);
		queue_req(cers_pkg::FUNC_DISC, 318, 50, 20, 0, 50, 16'h1111);
		queue_req(cers_pkg::FUNC_ELLIPSE, 160, 120, 30, 10, 120, 16'h2222);
		queue_req(cers_pkg::FUNC_ELLIPSE, 160, 120, 30, 10, 112, 16'h3333);
		queue_req(cers_pkg::FUNC_ELLIPSE, 160, 120, 1, 32767, 120, 16'h4444);
		queue_req(cers_pkg::FUNC_ELLIPSE, 160, 120, 32767, 1, 120, 16'h6666);
		queue_req(cers_pkg::FUNC_ELLIPSE, 160, 120, 30, 0, 120, 16'h7777);
		queue_req(cers_pkg::FUNC_DISC, 160, 120, 32767, 0, 120, 16'h9999);
		queue_req(cers_pkg::FUNC_CIRCLE, 32767, -32768, 32767, 0, 0, 16'hBBBB);
		queue_req(cers_pkg::FUNC_DISC, -32768, 0, 10, 0, 0, 16'hDDDD);
		queue_req(cers_pkg::FUNC_DISC, 0, 0, 5, 0, -32768, 16'hEEEE);
		queue_req(cers_pkg::FUNC_DISC, 0, 32767, 5, 0, 32767, 16'h0001);
		queue_req(cers_pkg::FUNC_CIRCLE, 100, 239, 3, 0, 240, 16'h8000);
		drain();

		// clipped window, sender mostly idle
		set_window(0, 0, 320, 240, 16, 8, 300, 200);
		idle_pct = 70;
		queue_random(90, -20, 340, 0, 240);
		drain();

		// window at the bottom of the coordinate range, full clip
		set_window(-32768, -32768, 4096, 4096, -32768, -32768, 32767, 32767);
		idle_pct = 38;
		queue_random(70, -32768, -28600, -32768, -28600);
		drain();

		// window pushed against the top of the coordinate range
		set_window(32000, 32000, 4096, 4096, 0, 0, 0, 0);
		idle_pct = 0;
		queue_random(70, 31800, 32767, 31800, 32767);
		drain();

		// empty surface gives nothing at all
		set_window(-200, 100, 0, 50, 5, 5, 1, 1);
		idle_pct = 70;
		queue_random(20, -200, 100, 100, 150);
		drain();

		// inverted clip rectangle leaves the surface alone in charge
		set_window(-50, -60, 200, 4096, 40, -20, -10, 100);
		idle_pct = 38;
		queue_random(40, -60, 160, -60, 200);
		idle_pct = 0;
		queue_random(40, -60, 160, -60, 200);
		drain();

		$display("covered %0d row requests over six window settings, %0d span words checked",
			reqs_taken, spans_seen);
		$display("shapes: disc, circle and ellipse outlines, bad codes, clipping and extremes");
		if (errors == 0)
			$display("circle_ellipse_row_spans test passed");
		else
			$display("circle_ellipse_row_spans test failed");
		$finish;
	end

endmodule
